>>> sv/spl_pkg.sv
// Shared types, constants and codes for the stable sorted priority list.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [19:0] PRIO_MIN = 20'd1;
  localparam logic [19:0] PRIO_MAX = 20'd1000000;

  // command codes
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_LIST_ALL  = 2'd1;
  localparam logic [1:0] CMD_LIST_DONE = 2'd2;
  localparam logic [1:0] CMD_LIST_PEND = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_ENTRY    = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_NOMATCH  = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_handle;
    logic [19:0] priority_req;
    logic        done_req;
  } spl_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_handle;
    logic [19:0] out_priority;
    logic        out_done;
    logic        last;
  } spl_out_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [19:0] prio;
    logic        done;
  } spl_entry_t;

  // row control: insert a new entry, or rotate the occupied part by one
  typedef struct packed {
    logic       ins;
    logic       rot;
    spl_entry_t new_ent;
  } spl_ctl_t;

endpackage

>>> sv/stable_sorted_priority_list_top.sv
// Top level: command decode, entry count, list sequencing and result register.
`timescale 1ns / 1ps
// Insert: row and result update in the cycle after start; a new item every cycle
//   when not busy. List: the occupied cells rotate once per cycle past the head
//   cell; results delayed by one match (last flag); empty table answers next cycle.
// Results come as one-cycle strobes on out_valid; the receiver cannot stall them.
// Reset (rst_n low, synchronous) empties the table and clears busy and out_valid.
module stable_sorted_priority_list_top
  import spl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spl_in_t  in_item,
  output logic     out_valid,
  output spl_out_t out_item
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [1:0]       filt_r, filt_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  spl_entry_t       hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  spl_out_t         out_r, out_nxt;

  spl_ctl_t   ctl;
  spl_entry_t head;
  logic       accept;
  logic       match;
  logic [19:0] prio_sat;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // clamp priority into the legal range
  always_comb begin
    if (in_item.priority_req < PRIO_MIN) begin
      prio_sat = PRIO_MIN;
    end else if (in_item.priority_req > PRIO_MAX) begin
      prio_sat = PRIO_MAX;
    end else begin
      prio_sat = in_item.priority_req;
    end
  end

  // filter on the entry now at the head
  always_comb begin
    case (filt_r)
      CMD_LIST_ALL:  match = 1'b1;
      CMD_LIST_DONE: match = head.done;
      CMD_LIST_PEND: match = ~head.done;
      default:       match = 1'b0;
    endcase
  end

  spl_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .head  (head)
  );

  // command and list sequencing
  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    filt_nxt      = filt_r;
    hold_vld_nxt  = hold_vld_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ctl.ins       = 1'b0;
    ctl.rot       = 1'b0;
    ctl.new_ent.handle = in_item.task_handle;
    ctl.new_ent.prio   = prio_sat;
    ctl.new_ent.done   = in_item.done_req;

    if (busy_r) begin
      if (step_r < count_r) begin
        // walk one entry past the head; emit the previous match
        ctl.rot  = 1'b1;
        step_nxt = step_r + CNT_W'(1);
        if (match) begin
          if (hold_vld_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt.kind         = KIND_ENTRY;
            out_nxt.out_handle   = hold_r.handle;
            out_nxt.out_priority = hold_r.prio;
            out_nxt.out_done     = hold_r.done;
          end
          hold_nxt     = head;
          hold_vld_nxt = 1'b1;
        end
      end else begin
        // row is back in place: flush the final result
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_nxt.last  = 1'b1;
        if (hold_vld_r) begin
          out_nxt.kind         = KIND_ENTRY;
          out_nxt.out_handle   = hold_r.handle;
          out_nxt.out_priority = hold_r.prio;
          out_nxt.out_done     = hold_r.done;
        end else begin
          out_nxt.kind = KIND_NOMATCH;
        end
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      out_nxt.last  = 1'b1;
      if (in_item.cmd == CMD_INSERT) begin
        if (count_r == CNT_W'(CAPACITY)) begin
          out_nxt.kind = KIND_FULL;
        end else begin
          ctl.ins      = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
          out_nxt.kind = KIND_INSERTED;
        end
      end else if (count_r == '0) begin
        out_nxt.kind = KIND_EMPTY;
      end else begin
        out_valid_nxt = 1'b0;
        busy_nxt      = 1'b1;
        step_nxt      = '0;
        filt_nxt      = in_item.cmd;
        hold_vld_nxt  = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      step_r      <= '0;
      filt_r      <= CMD_LIST_ALL;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      filt_r      <= filt_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.cmd == CMD_INSERT && count_r != CNT_W'(CAPACITY))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance entry count");

  a_entry_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_ENTRY) |-> $past(busy_r))
    else $error("entry result outside a list walk");

  a_not_last_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> busy_r)
    else $error("non-final result after list walk ended");

endmodule

>>> sv/spl_cell.sv
// One cell of the sorted row: holds one entry, inserts or rotates in step with its neighbors.
`timescale 1ns / 1ps
module spl_cell
  import spl_pkg::*;
(
  input  logic       clk,
  input  spl_ctl_t   ctl,
  input  logic       occ,
  input  logic       tail,
  input  logic       prev_keep,
  input  spl_entry_t prev_ent,
  input  spl_entry_t next_ent,
  input  spl_entry_t wrap_ent,
  output logic       keep,
  output spl_entry_t ent_r
);

  spl_entry_t ent_nxt;

  // stays put when occupied and not above the new priority (stable order)
  assign keep = occ & (ent_r.prio <= ctl.new_ent.prio);

  // next entry: on insert take the new one at the boundary, else shift from the left; on rotate take from the right
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (!keep) begin
        ent_nxt = prev_keep ? ctl.new_ent : prev_ent;
      end
    end else if (ctl.rot) begin
      ent_nxt = tail ? wrap_ent : next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> sv/spl_chain.sv
// Row of CAPACITY cells with neighbor links; head cell feeds the list readout.
`timescale 1ns / 1ps
module spl_chain
  import spl_pkg::*;
(
  input  logic             clk,
  input  spl_ctl_t         ctl,
  input  logic [CNT_W-1:0] count,
  output spl_entry_t       head
);

  spl_entry_t ent  [CAPACITY];
  logic       keep [CAPACITY];

  assign head = ent[0];

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic       occ;
      logic       tail;
      logic       pk;
      spl_entry_t pe;
      spl_entry_t ne;

      assign occ  = (CNT_W'(i) < count);
      assign tail = (CNT_W'(i + 1) == count);

      // left neighbor; cell 0 takes the new entry whenever it moves on insert
      if (i == 0) begin : g_first
        assign pk = 1'b1;
        assign pe = ctl.new_ent;
      end else begin : g_mid
        assign pk = keep[i-1];
        assign pe = ent[i-1];
      end

      // right neighbor; the far end wraps to the head
      if (i == CAPACITY - 1) begin : g_end
        assign ne = ent[0];
      end else begin : g_inner
        assign ne = ent[i+1];
      end

      spl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ),
        .tail      (tail),
        .prev_keep (pk),
        .prev_ent  (pe),
        .next_ent  (ne),
        .wrap_ent  (ent[0]),
        .keep      (keep[i]),
        .ent_r     (ent[i])
      );
    end
  endgenerate

endmodule
